/* src/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
package dq_pkg;

  // Operation carried with each input transaction.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Element and field widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 5;

  // Per-cycle command broadcast to every storage cell.
  typedef struct packed {
    logic shift_in;   // take the left neighbor's element (push at the front)
    logic shift_out;  // take the right neighbor's element (pop from the front)
    logic append;     // the cell at the fill position takes the new element
  } cell_ctrl_t;

endpackage

/* src/dq_cell.sv */
// One storage cell of the queue: holds the element at a fixed distance from the front.
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] push_value,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] back_data
);

  logic at_fill;
  logic at_tail;

  // Position of this cell relative to the current fill level.
  assign at_fill = (count == CW'(INDEX));
  assign at_tail = (count == CW'(INDEX + 1));

  // The element leaves through the back port only when this cell is the last one held.
  assign back_data = at_tail ? data : '0;

  // Shift toward the back, shift toward the front, or accept an appended element.
  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      data <= left_data;
    end else if (ctrl.shift_out) begin
      data <= right_data;
    end else if (ctrl.append && at_fill) begin
      data <= push_value;
    end
  end

endmodule

/* src/double_ended_queue.sv */
// Top level of the bounded double-ended queue built from a row of shifting cells.
//
// Usage:
//   Each input transaction on the s_ channel carries one operation in s_tuser
//   (push front, pop front, push back, pop back) and, for pushes, the element
//   in s_tdata. Each input transaction produces exactly one result transaction
//   on the m_ channel: the popped element and the fill count in m_tdata, the
//   status in m_tuser (ok, pop on empty, push on full).
//   Elements sit in a row of CAPACITY cells, front element in cell 0. A push or
//   pop at the front shifts the whole row by one place; a push at the back
//   writes the cell at the fill position and a pop at the back reads the last
//   held cell.
//   The result is registered and becomes valid in the cycle after the input
//   transaction; with its single output register the block takes one operation every cycle while results are taken.
//   When the receiver stalls, the result waits in the output register and
//   s_tready stays low until it is taken.
//   Reset empties the queue and drops any pending result; cell contents are
//   not cleared since no cell is read before it is written.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] push_value
  input  logic [1:0]  s_tuser,  // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] popped_value, [36:32] fill_count, [39:37] zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              xfer;
  logic              full;
  logic              empty;
  op_t               op;
  cell_ctrl_t        ctrl;
  cell_ctrl_t        cell_ctrl;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] popped_next;
  logic [DATA_W-1:0] back_any;
  logic [DATA_W-1:0] out_popped;
  logic [1:0]        out_status;
  logic [FILL_W-1:0] out_fill;

  logic [DATA_W-1:0] cell_data  [CAPACITY];
  logic [DATA_W-1:0] back_data  [CAPACITY];
  logic [DATA_W-1:0] left_data  [CAPACITY];
  logic [DATA_W-1:0] right_data [CAPACITY];

  // Accept a new operation whenever the output register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign xfer     = s_tvalid && s_tready;

  assign op    = op_t'(s_tuser);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // Collect the last held element; at most one cell drives it.
  always_comb begin
    back_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_any = back_any | back_data[i];
    end
  end

  // Decode the operation into a cell command, status, popped element and new count.
  always_comb begin
    ctrl        = '0;
    status_next = ST_OK;
    popped_next = '0;
    count_next  = count;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.shift_in = 1'b1;
          count_next    = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.shift_out = 1'b1;
          popped_next    = cell_data[0];
          count_next     = count - CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.append = 1'b1;
          count_next  = count + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = back_any;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Cells act only on an accepted transaction.
  assign cell_ctrl = xfer ? ctrl : '0;

  // Row of cells, each wired to its neighbors; the ends take the new element or hold.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_data[g] = s_tdata;
    end else begin : g_inner_l
      assign left_data[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_data[g] = cell_data[g];
    end else begin : g_inner_r
      assign right_data[g] = cell_data[g+1];
    end

    dq_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .count      (count),
      .push_value (s_tdata),
      .left_data  (left_data[g]),
      .right_data (right_data[g]),
      .data       (cell_data[g]),
      .back_data  (back_data[g])
    );
  end

  // Fill count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (xfer) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (xfer) begin
      out_popped <= popped_next;
      out_status <= status_next;
      out_fill   <= FILL_W'(count_next);
    end
  end

  assign m_tdata = {3'b000, out_fill, out_popped};
  assign m_tuser = out_status;

  // The fill level never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  // A push that was accepted on a non-full queue grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (xfer && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full)
      |=> count == $past(count) + CW'(1))
    else $error("successful push did not grow the queue");

  // A full status is reported only with a full queue and carries no element.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (count == CW'(CAPACITY) && out_popped == '0))
    else $error("full status reported on a queue that is not full");

  // An empty status leaves the queue empty and carries no element.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (out_fill == '0 && out_popped == '0))
    else $error("empty status reported with elements held");

endmodule

/* test/tb_double_ended_queue.sv */
// Self-checking testbench for the double-ended queue with a ring-buffer mirror of its contents.
`timescale 1ns / 100ps

module tb_double_ended_queue
  import dq_pkg::*;
;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned NUM_RANDOM = 1350;
  localparam int unsigned STALL_LIMIT = 5000;

  // Expected outcome of one operation, matching the result fields.
  typedef struct packed {
    logic [31:0] popped;
    logic [1:0]  status;
    logic [4:0]  fill;
  } outcome_t;

  // Mirror of the queue contents; predicts and checks each outcome.
  class deque_mirror;
    logic [31:0] slots [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned held;
    outcome_t    op_outcomes [$];
    int unsigned errors;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return op_outcomes.size();
    endfunction

    // Applies one accepted operation to the mirror and queues its outcome.
    function void apply_op(op_t op, logic [31:0] value);
      outcome_t res;
      res = '0;
      res.status = ST_OK;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head = (head == 0) ? DEPTH - 1 : head - 1;
          slots[head] = value;
          held++;
        end else begin
          slots[tail] = value;
          tail = (tail + 1 >= DEPTH) ? 0 : tail + 1;
          held++;
        end
      end else begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          res.popped = slots[head];
          head = (head + 1 >= DEPTH) ? 0 : head + 1;
          held--;
        end else begin
          tail = (tail == 0) ? DEPTH - 1 : tail - 1;
          res.popped = slots[tail];
          held--;
        end
      end
      res.fill = held[4:0];
      op_outcomes.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one accepted result transaction with the oldest outcome.
    task check_outcome(logic [39:0] data, logic [1:0] user);
      outcome_t want;
      if (op_outcomes.size() == 0) begin
        report($sformatf("result with nothing pending, data %h status %0d", data, user));
      end else begin
        want = op_outcomes.pop_front();
        if (data[31:0] !== want.popped)
          report($sformatf("popped value %h, expected %h", data[31:0], want.popped));
        if (user !== want.status)
          report($sformatf("status %0d, expected %0d", user, want.status));
        if (data[36:32] !== want.fill)
          report($sformatf("fill count %0d, expected %0d", data[36:32], want.fill));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] push_value
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] popped_value, [36:32] fill_count, [39:37] zero
  logic [1:0]  m_tuser;        // [1:0] status

  logic        steady_phase = 1'b0;
  int unsigned stall_count = 0;
  deque_mirror mirror = new();

  double_ended_queue #(.CAPACITY(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Presents one operation, with a random idle gap first outside the steady phase, and waits for the transaction.
  task automatic send_op(op_t op, logic [31:0] value);
    while (!steady_phase && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    mirror.apply_op(op, value);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // Picks a push value, favoring the extremes now and then.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(15))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = 32'h0000_0000;
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: random backpressure, and the check of every result transaction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        mirror.check_outcome(m_tdata, m_tuser);
      m_tready <= steady_phase ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAIL double_ended_queue");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Stimulus: directed corners, then random runs with a drifting push bias.
  initial begin
    int unsigned push_bias;
    op_t         op;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops on an empty queue from both ends.
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_BACK, 32'h1234_5678);
    // Fill to capacity from both ends with extreme values.
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        1: send_op(OP_PUSH_BACK, 32'h8000_0000);
        2: send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF - i);
        default: send_op(OP_PUSH_BACK, 32'h0000_0000 + i);
      endcase
    end
    // Pushes on a full queue are refused at both ends.
    send_op(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    drain_results();

    push_bias = 50;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 40 == 0)
        push_bias = $urandom_range(10, 90);
      steady_phase <= (i >= 500 && i < 800);
      if (i == 1000)
        drain_results();
      if ($urandom_range(99) < push_bias)
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      send_op(op, pick_value());
    end

    // Let every result come out, then allow for the output register.
    s_tvalid <= 1'b0;
    steady_phase <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.errors == 0)
      $display("PASS double_ended_queue");
    else
      $display("FAIL double_ended_queue");
    $finish;
  end

endmodule
